@@ rtl/core/salsa_pkg.sv @@
// Shared types, constants and helper functions for the Salsa20/20 stream cipher core.
// Used by salsa_seq, the top level, the checker and the testbench. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package salsa_pkg;

  // Configuration register indexes
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] CFG_KEY0  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_KEY1  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_KEY2  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_KEY3  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_MODE  = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_NONCE = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_START = 3'd6;

  // "expand 32-byte k" (sigma) and "expand 16-byte k" (tau) diagonal words
  localparam logic [31:0] CONST_W0       = 32'h61707865;
  localparam logic [31:0] SIGMA_W5       = 32'h3320646e;
  localparam logic [31:0] SIGMA_W10      = 32'h79622d32;
  localparam logic [31:0] TAU_W5         = 32'h3120646e;
  localparam logic [31:0] TAU_W10        = 32'h79622d36;
  localparam logic [31:0] CONST_W15      = 32'h6b206574;

  // 10 double rounds = 20 rounds x 4 quarter rounds x 4 add-rotate-xor steps
  localparam int STEP_W = 9;
  localparam logic [STEP_W-1:0] LAST_STEP = 9'd319;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LOAD,
    SEQ_ROUND,
    SEQ_FF
  } seq_state_t;

  typedef enum logic [1:0] {
    PH_SRC,
    PH_DST,
    PH_WB
  } phase_t;

  typedef enum logic [1:0] {
    WR_INIT,
    WR_XOR,
    WR_SUM
  } wr_src_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_GEN,
    CS_READ,
    CS_OUT
  } core_state_t;

  // Sequencer controls toward the working-state memory and the shared unit
  typedef struct packed {
    logic       wr_en;
    logic [3:0] wr_addr;
    wr_src_t    wr_src;
    logic [3:0] rd0_addr;
    logic [3:0] rd1_addr;
    logic       unit_en;
    logic       unit_ff;
    logic [4:0] rot;
    logic [3:0] init_idx;
    logic       done;
  } seq_ctl_t;

  // Word index of quarter-round role pos (a=0, b=1, c=2, d=3)
  function automatic logic [3:0] qr_word(input logic row, input logic [1:0] qr,
                                         input logic [1:0] pos);
    logic [15:0] quad;
    quad = 16'h0000;
    case ({row, qr})
      3'b000:  quad = {4'd12, 4'd8,  4'd4,  4'd0};
      3'b001:  quad = {4'd1,  4'd13, 4'd9,  4'd5};
      3'b010:  quad = {4'd6,  4'd2,  4'd14, 4'd10};
      3'b011:  quad = {4'd11, 4'd7,  4'd3,  4'd15};
      3'b100:  quad = {4'd3,  4'd2,  4'd1,  4'd0};
      3'b101:  quad = {4'd4,  4'd7,  4'd6,  4'd5};
      3'b110:  quad = {4'd9,  4'd8,  4'd11, 4'd10};
      3'b111:  quad = {4'd14, 4'd13, 4'd12, 4'd15};
      default: quad = 16'h0000;
    endcase
    return quad[{pos, 2'b00} +: 4];
  endfunction

  // Rotate distance of each step of a quarter round
  function automatic logic [4:0] step_rot(input logic [1:0] st);
    logic [4:0] r;
    r = 5'd0;
    case (st)
      2'd0:    r = 5'd7;
      2'd1:    r = 5'd9;
      2'd2:    r = 5'd13;
      2'd3:    r = 5'd18;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/salsa_arx.sv @@
// Shared add-rotate unit: one 32-bit add and a left rotate, result registered.
// Does not depend on salsa_pkg; no package items are needed here.
`timescale 1ns / 1ps
`default_nettype none

module salsa_arx (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] op_a,
  input  wire logic [31:0] op_b,
  input  wire logic [4:0]  rot,
  output logic [31:0]      res_r
);

  logic [31:0] sum;
  logic [63:0] dbl;
  logic [31:0] res_nxt;

  always_comb begin
    sum     = op_a + op_b;
    dbl     = {sum, sum} << rot;
    res_nxt = dbl[63:32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/salsa_seq.sv @@
// Block sequencer: load, 320 add-rotate-xor steps, 16 feed-forward adds.
// Depends on salsa_pkg for the control struct, state enums and round tables.
`timescale 1ns / 1ps
`default_nettype none

module salsa_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output salsa_pkg::seq_ctl_t ctl
);
  import salsa_pkg::*;

  seq_state_t        state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [3:0]        idx_r, idx_nxt;

  logic       row;
  logic [1:0] qr;
  logic [1:0] st;
  logic [3:0] wx, wy, wz;

  always_comb begin
    row = step_r[4];
    qr  = step_r[3:2];
    st  = step_r[1:0];
    wx  = qr_word(row, qr, st + 2'd1);
    wy  = qr_word(row, qr, st);
    wz  = qr_word(row, qr, st + 2'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      phase_r <= PH_SRC;
      step_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    ctl       = '0;
    ctl.wr_src = WR_INIT;
    case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          state_nxt = SEQ_LOAD;
          idx_nxt   = '0;
        end
      end
      SEQ_LOAD: begin
        ctl.wr_en    = 1'b1;
        ctl.wr_addr  = idx_r;
        ctl.wr_src   = WR_INIT;
        ctl.init_idx = idx_r;
        idx_nxt      = idx_r + 4'd1;
        if (idx_r == 4'd15) begin
          state_nxt = SEQ_ROUND;
          phase_nxt = PH_SRC;
          step_nxt  = '0;
        end
      end
      SEQ_ROUND: begin
        case (phase_r)
          PH_SRC: begin
            ctl.rd0_addr = wy;
            ctl.rd1_addr = wz;
            phase_nxt    = PH_DST;
          end
          PH_DST: begin
            ctl.rd0_addr = wx;
            ctl.unit_en  = 1'b1;
            ctl.rot      = step_rot(st);
            phase_nxt    = PH_WB;
          end
          PH_WB: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = wx;
            ctl.wr_src  = WR_XOR;
            phase_nxt   = PH_SRC;
            step_nxt    = step_r + 9'd1;
            if (step_r == LAST_STEP) begin
              state_nxt = SEQ_FF;
              idx_nxt   = '0;
            end
          end
          default: phase_nxt = PH_SRC;
        endcase
      end
      SEQ_FF: begin
        case (phase_r)
          PH_SRC: begin
            ctl.rd0_addr = idx_r;
            phase_nxt    = PH_DST;
          end
          PH_DST: begin
            ctl.unit_en  = 1'b1;
            ctl.unit_ff  = 1'b1;
            ctl.init_idx = idx_r;
            phase_nxt    = PH_WB;
          end
          PH_WB: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = idx_r;
            ctl.wr_src  = WR_SUM;
            phase_nxt   = PH_SRC;
            idx_nxt     = idx_r + 4'd1;
            if (idx_r == 4'd15) begin
              ctl.done  = 1'b1;
              state_nxt = SEQ_IDLE;
            end
          end
          default: phase_nxt = PH_SRC;
        endcase
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/salsa20_stream_cipher_core.sv @@
// Top level of the Salsa20/20 stream cipher core: config registers, byte FSM,
// working-state memory. Depends on salsa_pkg, salsa_seq and salsa_arx.
`timescale 1ns / 1ps
`default_nettype none

// Salsa20/20 byte-stream cipher. Each input transaction carries one byte and
// a first-of-message flag; each output transaction carries that byte XORed
// with the next keystream byte. A first byte reloads the block counter from
// start_counter (high word zero) and resets the byte position. Whenever the
// position is 0 a fresh 64-byte block is computed in a 16 x 32 working
// memory with two read ports and one write port, driven by one shared
// add-rotate unit under a sequencer: 16 loads, 320 add-rotate-xor steps
// (read operands, read target and add-rotate, XOR and write back) and 16
// feed-forward adds. A byte that opens a block waits for that block and
// then for a memory read and its result; every other byte goes through
// accept, memory read and result. The result sits in an output register,
// so a new byte is accepted while it waits. Write configuration only while
// idle; key, nonce and mode take effect at the next block, start_counter at
// the next first byte.
module salsa20_stream_cipher_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input stream
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,   // [7:0] data_in
  input  wire logic                        in_tuser,   // [0] first_byte
  // output stream
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [7:0]                       out_tdata,  // [7:0] data_out
  // configuration write port
  input  wire logic                        cfg_we,
  input  wire logic [salsa_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [63:0]                 cfg_wdata
);
  import salsa_pkg::*;

  // Configuration registers
  logic [63:0] key0_r, key1_r, key2_r, key3_r, nonce_r;
  logic        mode_r;
  logic [31:0] start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r  <= '0;
      key1_r  <= '0;
      key2_r  <= '0;
      key3_r  <= '0;
      mode_r  <= 1'b1;
      nonce_r <= '0;
      start_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_KEY0:  key0_r  <= cfg_wdata;
        CFG_KEY1:  key1_r  <= cfg_wdata;
        CFG_KEY2:  key2_r  <= cfg_wdata;
        CFG_KEY3:  key3_r  <= cfg_wdata;
        CFG_MODE:  mode_r  <= cfg_wdata[0];
        CFG_NONCE: nonce_r <= cfg_wdata;
        CFG_START: start_r <= cfg_wdata[31:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Byte control
  core_state_t state_r, state_nxt;
  logic [63:0] ctr_r, ctr_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [7:0]  din_r, din_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic        seq_start;

  seq_ctl_t    ctl;

  // Working-state memory and shared unit
  logic [31:0] work_mem [16];
  logic [31:0] rd0_q, rd1_q;
  logic [3:0]  rd0_addr;
  logic [31:0] wr_data;
  logic [31:0] init_word;
  logic [31:0] unit_b;
  logic [31:0] unit_q;
  logic [63:0] hi0, hi1;
  logic [7:0]  ks_byte;

  salsa_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (seq_start),
    .ctl   (ctl)
  );

  salsa_arx u_arx (
    .clk   (clk),
    .en    (ctl.unit_en),
    .op_a  (rd0_q),
    .op_b  (unit_b),
    .rot   (ctl.rot),
    .res_r (unit_q)
  );

  // Block input words, selected by the sequencer's word index
  always_comb begin
    hi0       = mode_r ? key2_r : key0_r;
    hi1       = mode_r ? key3_r : key1_r;
    init_word = '0;
    case (ctl.init_idx)
      4'd0:    init_word = CONST_W0;
      4'd1:    init_word = key0_r[31:0];
      4'd2:    init_word = key0_r[63:32];
      4'd3:    init_word = key1_r[31:0];
      4'd4:    init_word = key1_r[63:32];
      4'd5:    init_word = mode_r ? SIGMA_W5 : TAU_W5;
      4'd6:    init_word = nonce_r[31:0];
      4'd7:    init_word = nonce_r[63:32];
      4'd8:    init_word = ctr_r[31:0];
      4'd9:    init_word = ctr_r[63:32];
      4'd10:   init_word = mode_r ? SIGMA_W10 : TAU_W10;
      4'd11:   init_word = hi0[31:0];
      4'd12:   init_word = hi0[63:32];
      4'd13:   init_word = hi1[31:0];
      4'd14:   init_word = hi1[63:32];
      4'd15:   init_word = CONST_W15;
      default: init_word = '0;
    endcase
  end

  always_comb begin
    unit_b   = ctl.unit_ff ? init_word : rd1_q;
    // Outside block generation, port 0 follows the current keystream word
    rd0_addr = (state_r == CS_GEN) ? ctl.rd0_addr : pos_r[5:2];
    wr_data  = '0;
    case (ctl.wr_src)
      WR_INIT: wr_data = init_word;
      WR_XOR:  wr_data = rd0_q ^ unit_q;
      WR_SUM:  wr_data = unit_q;
      default: wr_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      work_mem[ctl.wr_addr] <= wr_data;
    end
    rd0_q <= work_mem[rd0_addr];
    rd1_q <= work_mem[ctl.rd1_addr];
  end

  always_comb begin
    ks_byte = '0;
    case (pos_r[1:0])
      2'd0:    ks_byte = rd0_q[7:0];
      2'd1:    ks_byte = rd0_q[15:8];
      2'd2:    ks_byte = rd0_q[23:16];
      2'd3:    ks_byte = rd0_q[31:24];
      default: ks_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      ctr_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctr_r       <= ctr_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    din_r      <= din_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ctr_nxt       = ctr_r;
    pos_nxt       = pos_r;
    din_nxt       = din_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    seq_start     = 1'b0;
    in_tready     = (state_r == CS_IDLE);

    // Drop the held result once the sink takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      CS_IDLE: begin
        if (in_tvalid) begin
          din_nxt = in_tdata;
          if (in_tuser) begin
            pos_nxt   = '0;
            ctr_nxt   = {32'd0, start_r};
            seq_start = 1'b1;
            state_nxt = CS_GEN;
          end else if (pos_r == 6'd0) begin
            seq_start = 1'b1;
            state_nxt = CS_GEN;
          end else begin
            state_nxt = CS_READ;
          end
        end
      end
      CS_GEN: begin
        // Advance the counter once the block is in memory
        if (ctl.done) begin
          ctr_nxt   = ctr_r + 64'd1;
          state_nxt = CS_READ;
        end
      end
      CS_READ: begin
        state_nxt = CS_OUT;
      end
      CS_OUT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = din_r ^ ks_byte;
          out_valid_nxt = 1'b1;
          pos_nxt       = pos_r + 6'd1;
          state_nxt     = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/core/salsa_chk.sv @@
// Port-level checker for salsa20_stream_cipher_core, attached by bind below.
// Depends on salsa_pkg for the configuration index width.
`timescale 1ns / 1ps
`default_nettype none

module salsa_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic [7:0]                  in_tdata,
  input wire logic                        in_tuser,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [7:0]                  out_tdata,
  input wire logic                        cfg_we,
  input wire logic [salsa_pkg::CFG_AW-1:0] cfg_addr,
  input wire logic [63:0]                 cfg_wdata
);
  import salsa_pkg::*;

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // One byte at a time: an accepted byte closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted byte");

  // A new result is loaded only while the input side is closed
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while input was idle");

  // A first byte starts a block, which keeps the input closed for a while
  a_first_gen: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> ##3 !in_tready)
    else $error("block generation ended too early");

  // Controls stay known, and so do offered bytes and register writes
  a_known_inputs: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_tvalid, cfg_we}) &&
    (!in_tvalid || !$isunknown({in_tuser, in_tdata})) &&
    (!cfg_we || !$isunknown({cfg_addr, cfg_wdata})))
    else $error("unknown value on an offered byte or register write");

endmodule

bind salsa20_stream_cipher_core salsa_chk u_salsa_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_we     (cfg_we),
  .cfg_addr   (cfg_addr),
  .cfg_wdata  (cfg_wdata)
);

`default_nettype wire

@@ dv/salsa20_stream_cipher_core_test.sv @@
// Self-checking testbench for salsa20_stream_cipher_core: directed table, then random messages.
// Depends on salsa_pkg and the core RTL; expected bytes come from a Salsa20/20 predictor below.
`timescale 1ns / 1ps

module salsa20_stream_cipher_core_test;
  import salsa_pkg::*;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_AW-1:0] CFG_UNMAPPED = 3'd7;

  // Worst case for this stimulus is about 1400 bytes that each open a block,
  // plus sender gaps and receiver stalls.
  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int NUM_PHASES   = 9;
  localparam int PHASE_ITEMS  = 150;
  localparam int BLOCK_CYCLES = 1100;
  localparam int PRINT_LIMIT  = 50;

  typedef enum logic [1:0] {
    ROW_DATA,   // byte that continues the message
    ROW_FIRST,  // byte that restarts the message
    ROW_CFG     // register write, issued only once the core has drained
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [CFG_AW-1:0] idx;
    logic [63:0]       val;  // register value, or the byte in [7:0]
  } stim_row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_RUNS
  } rx_mode_t;

  // Keystream bytes cannot be read off by eye, so every row is checked
  // against the predictor.
  localparam int DIR_ROWS = 42;
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    // Straight out of reset: 256-bit mode, zero key and nonce, counter 0,
    // and no first byte to open the message.
    '{ROW_DATA,  CFG_UNMAPPED, 64'h00},
    '{ROW_DATA,  CFG_UNMAPPED, 64'hff},
    '{ROW_DATA,  CFG_UNMAPPED, 64'h01},
    '{ROW_DATA,  CFG_UNMAPPED, 64'h80},
    '{ROW_FIRST, CFG_UNMAPPED, 64'ha5},
    '{ROW_DATA,  CFG_UNMAPPED, 64'h5a},
    // Back-to-back restarts: each one rebuilds block 0.
    '{ROW_FIRST, CFG_UNMAPPED, 64'h00},
    '{ROW_FIRST, CFG_UNMAPPED, 64'hff},
    '{ROW_FIRST, CFG_UNMAPPED, 64'h0f},
    // All-ones extremes, start counter at its top value.
    '{ROW_CFG,   CFG_KEY0,     64'hffff_ffff_ffff_ffff},
    '{ROW_CFG,   CFG_KEY1,     64'hffff_ffff_ffff_ffff},
    '{ROW_CFG,   CFG_KEY2,     64'hffff_ffff_ffff_ffff},
    '{ROW_CFG,   CFG_KEY3,     64'hffff_ffff_ffff_ffff},
    '{ROW_CFG,   CFG_NONCE,    64'hffff_ffff_ffff_ffff},
    '{ROW_CFG,   CFG_START,    64'hffff_ffff_ffff_ffff},
    '{ROW_CFG,   CFG_MODE,     64'hffff_ffff_ffff_ffff},
    '{ROW_FIRST, CFG_UNMAPPED, 64'h00},
    '{ROW_DATA,  CFG_UNMAPPED, 64'hff},
    '{ROW_DATA,  CFG_UNMAPPED, 64'h3c},
    // 128-bit mode via bit 0 only, plus a write to the unmapped index.
    '{ROW_CFG,   CFG_MODE,     64'hffff_ffff_ffff_fffe},
    '{ROW_CFG,   CFG_UNMAPPED, 64'h0123_4567_89ab_cdef},
    '{ROW_FIRST, CFG_UNMAPPED, 64'hc3},
    '{ROW_DATA,  CFG_UNMAPPED, 64'h00},
    '{ROW_DATA,  CFG_UNMAPPED, 64'hff},
    // Key change mid-block: the next byte still uses the old block.
    '{ROW_CFG,   CFG_KEY0,     64'h0},
    '{ROW_CFG,   CFG_KEY1,     64'h0},
    '{ROW_CFG,   CFG_KEY2,     64'h0706_0504_0302_0100},
    '{ROW_CFG,   CFG_NONCE,    64'h0},
    '{ROW_CFG,   CFG_START,    64'h0},
    '{ROW_DATA,  CFG_UNMAPPED, 64'h11},
    '{ROW_FIRST, CFG_UNMAPPED, 64'h22},
    '{ROW_DATA,  CFG_UNMAPPED, 64'hee},
    // Back to 256-bit mode; the upper half of the start write is dropped.
    '{ROW_CFG,   CFG_KEY1,     64'h8000_0000_0000_0001},
    '{ROW_CFG,   CFG_KEY3,     64'h8000_0000_0000_0001},
    '{ROW_CFG,   CFG_MODE,     64'h1},
    '{ROW_CFG,   CFG_START,    64'hffff_ffff_0000_0001},
    '{ROW_FIRST, CFG_UNMAPPED, 64'h7e},
    '{ROW_DATA,  CFG_UNMAPPED, 64'h81},
    '{ROW_DATA,  CFG_UNMAPPED, 64'hff},
    '{ROW_DATA,  CFG_UNMAPPED, 64'h00},
    '{ROW_FIRST, CFG_UNMAPPED, 64'h96},
    '{ROW_DATA,  CFG_UNMAPPED, 64'h69}
  };

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = 8'h00;  // [7:0] data_in
  logic              in_tuser   = 1'b0;   // [0] first_byte
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;           // [7:0] data_out
  logic              cfg_we     = 1'b0;
  logic [CFG_AW-1:0] cfg_addr   = CFG_KEY0;
  logic [63:0]       cfg_wdata  = 64'd0;

  // Predictor state: register mirror and cipher state
  logic [63:0] m_key0, m_key1, m_key2, m_key3, m_nonce;
  logic        m_wide;
  logic [31:0] m_start;
  logic [31:0] ks_word [16];
  logic [31:0] mix [16];
  logic [63:0] blk_ctr;
  logic [5:0]  blk_pos;

  logic [7:0] expected_bytes [$];
  logic [7:0] want_byte;
  int         mismatches  = 0;
  int         cycle_count = 0;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_run  = 0;

  salsa20_stream_cipher_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void mix_quarter(input int a, input int b, input int c, input int d);
    mix[b] = mix[b] ^ rotl32(mix[a] + mix[d], 7);
    mix[c] = mix[c] ^ rotl32(mix[b] + mix[a], 9);
    mix[d] = mix[d] ^ rotl32(mix[c] + mix[b], 13);
    mix[a] = mix[a] ^ rotl32(mix[d] + mix[c], 18);
  endfunction

  // Build the next 64-byte keystream block from the mirrored registers.
  function automatic void refill_keystream();
    logic [31:0] init [16];
    logic [63:0] hi0;
    logic [63:0] hi1;
    hi0 = m_wide ? m_key2 : m_key0;
    hi1 = m_wide ? m_key3 : m_key1;
    init[0]  = CONST_W0;
    init[5]  = m_wide ? SIGMA_W5 : TAU_W5;
    init[10] = m_wide ? SIGMA_W10 : TAU_W10;
    init[15] = CONST_W15;
    init[1]  = m_key0[31:0];
    init[2]  = m_key0[63:32];
    init[3]  = m_key1[31:0];
    init[4]  = m_key1[63:32];
    init[11] = hi0[31:0];
    init[12] = hi0[63:32];
    init[13] = hi1[31:0];
    init[14] = hi1[63:32];
    init[6]  = m_nonce[31:0];
    init[7]  = m_nonce[63:32];
    init[8]  = blk_ctr[31:0];
    init[9]  = blk_ctr[63:32];
    for (int i = 0; i < 16; i++) mix[i] = init[i];
    for (int r = 0; r < 10; r++) begin
      // column round
      mix_quarter(0, 4, 8, 12);
      mix_quarter(5, 9, 13, 1);
      mix_quarter(10, 14, 2, 6);
      mix_quarter(15, 3, 7, 11);
      // row round
      mix_quarter(0, 1, 2, 3);
      mix_quarter(5, 6, 7, 4);
      mix_quarter(10, 11, 8, 9);
      mix_quarter(15, 12, 13, 14);
    end
    for (int i = 0; i < 16; i++) ks_word[i] = mix[i] + init[i];
  endfunction

  // Advance the cipher by one byte and return the expected output byte.
  function automatic logic [7:0] cipher_byte(input logic first, input logic [7:0] data);
    logic [31:0] w;
    if (first) begin
      blk_pos = 6'd0;
      blk_ctr = {32'd0, m_start};
    end
    if (blk_pos == 6'd0) begin
      refill_keystream();
      blk_ctr = blk_ctr + 64'd1;
    end
    w = ks_word[blk_pos[5:2]];
    blk_pos = blk_pos + 6'd1;
    return data ^ w[{blk_pos[1:0] - 2'd1, 3'b000} +: 8];
  endfunction

  function automatic void mirror_reg(input logic [CFG_AW-1:0] idx, input logic [63:0] val);
    case (idx)
      CFG_KEY0:  m_key0  = val;
      CFG_KEY1:  m_key1  = val;
      CFG_KEY2:  m_key2  = val;
      CFG_KEY3:  m_key3  = val;
      CFG_MODE:  m_wide  = val[0];
      CFG_NONCE: m_nonce = val;
      CFG_START: m_start = val[31:0];
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return 64'd0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] pick_start();
    logic [31:0] lo;
    case ($urandom_range(0, 3))
      0:       lo = 32'd0;
      1:       lo = 32'hffff_ffff;
      2:       lo = 32'hffff_fffe;
      default: lo = $urandom;
    endcase
    return {$urandom, lo};
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("[%0t] %s: got %02h, want %02h", $time, what, got, want);
  endtask

  // Offer one byte, hold it until the transaction completes, then predict.
  task automatic push_byte(input logic first, input logic [7:0] data);
    in_tvalid <= 1'b1;
    in_tuser  <= first;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_bytes.push_back(cipher_byte(first, data));
  endtask

  // Drop valid for a gap of length n; n of zero leaves valid alone.
  task automatic hold_input(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every outstanding byte to come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write per cycle; the caller lowers cfg_we after a batch.
  task automatic cfg_put(input logic [CFG_AW-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    mirror_reg(idx, val);
  endtask

  // Rewrite a random subset of registers; force a top start value on request
  // so that a long message carries into the counter's high word.
  task automatic shuffle_regs(input bit force_carry);
    if ($urandom_range(0, 2) != 0) cfg_put(CFG_KEY0, pick_word());
    if ($urandom_range(0, 2) != 0) cfg_put(CFG_KEY1, pick_word());
    if ($urandom_range(0, 2) != 0) cfg_put(CFG_KEY2, pick_word());
    if ($urandom_range(0, 2) != 0) cfg_put(CFG_KEY3, pick_word());
    if ($urandom_range(0, 1) != 0) cfg_put(CFG_MODE, {$urandom, $urandom});
    if ($urandom_range(0, 2) != 0) cfg_put(CFG_NONCE, pick_word());
    if (force_carry) cfg_put(CFG_START, {$urandom, 32'hffff_ffff});
    else if ($urandom_range(0, 2) != 0) cfg_put(CFG_START, pick_start());
    if ($urandom_range(0, 3) == 0) cfg_put(CFG_UNMAPPED, pick_word());
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: check each output transaction and stall on a shifting pattern
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected output byte", out_tdata, 8'h00);
      end else begin
        want_byte = expected_bytes.pop_front();
        if (out_tdata !== want_byte) report_mismatch("data_out", out_tdata, want_byte);
      end
    end
    // switch the stall pattern at random intervals
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(32, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        // alternate runs of ready and stall of random length
        if (rx_run == 0) begin
          out_tready <= ~out_tready;
          rx_run     <= $urandom_range(0, 7);
        end else begin
          rx_run <= rx_run - 1;
        end
      end
    endcase
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("salsa20_stream_cipher_core_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    bit   prev_cfg;
    logic first;
    int   burst_left;
    int   restart_run;
    int   first_odds;
    bit   no_gaps;

    // mirror the reset values of the registers and the cipher state
    m_key0  = 64'd0;
    m_key1  = 64'd0;
    m_key2  = 64'd0;
    m_key3  = 64'd0;
    m_wide  = 1'b1;
    m_nonce = 64'd0;
    m_start = 32'd0;
    blk_ctr = 64'd0;
    blk_pos = 6'd0;
    for (int i = 0; i < 16; i++) ks_word[i] = 32'd0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: walk the table, draining before each batch of writes.
    prev_cfg = 1'b0;
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].kind == ROW_CFG) begin
        if (!prev_cfg) drain();
        cfg_put(DIR_TABLE[r].idx, DIR_TABLE[r].val);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_we <= 1'b0;
        push_byte(DIR_TABLE[r].kind == ROW_FIRST, DIR_TABLE[r].val[7:0]);
        prev_cfg = 1'b0;
      end
    end
    drain();

    // Random part: phases of messages under changing keys and modes.
    for (int p = 0; p < NUM_PHASES; p++) begin
      shuffle_regs(p == 0);
      // short messages in some phases, long ones crossing blocks in others
      first_odds  = (p == 0 || $urandom_range(0, 1) == 0) ? 100 : 16;
      no_gaps     = ($urandom_range(0, 3) == 0);
      burst_left  = $urandom_range(1, 48);
      restart_run = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (restart_run == 0 && $urandom_range(0, 199) == 0)
          restart_run = $urandom_range(2, 5);
        first = (restart_run > 0) || ($urandom_range(0, first_odds - 1) == 0);
        // phase 0 always restarts so the counter carry is reached
        if (n == 0) first = (p == 0) || ($urandom_range(0, 1) == 0);
        if (restart_run > 0) restart_run--;
        push_byte(first, 8'($urandom_range(0, 255)));
        burst_left--;
        if (burst_left == 0) begin
          hold_input(no_gaps ? 0 : $urandom_range(0, 8));
          burst_left = $urandom_range(1, 48);
        end
        // now and then let the pipeline run dry mid-message
        if ($urandom_range(0, 299) == 0) drain();
      end
      drain();
    end

    // Allow a full block time for any stray output to show up.
    repeat (BLOCK_CYCLES) @(posedge clk);
    while (expected_bytes.size() != 0) begin
      report_mismatch("missing output byte", 8'h00, expected_bytes.pop_front());
    end
    if (mismatches == 0) begin
      $display("salsa20_stream_cipher_core_test passed");
    end else begin
      $display("salsa20_stream_cipher_core_test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/salsa_pkg.sv
rtl/core/salsa_arx.sv
rtl/core/salsa_seq.sv
rtl/core/salsa20_stream_cipher_core.sv
rtl/core/salsa_chk.sv
dv/salsa20_stream_cipher_core_test.sv
